// ===== hdl/ides_pkg.sv =====
// Package for the ISO9660 directory entry search block.
// Holds beat types, status codes, register indexes, record layout constants
// and the character fold helper. No dependencies.
package ides_pkg;

   // Default sizing, used as parameter defaults on the top level
   localparam int SECTOR_BYTES_DEF        = 2048;
   localparam int MAX_DIRECTORY_BYTES_DEF = 16384;
   localparam int MAX_NAME_CHARS_DEF      = 16;

   // Directory record layout
   localparam logic [7:0] MIN_RECORD_LEN = 8'd34;
   localparam logic [7:0] EXTENT_FIRST   = 8'd2;
   localparam logic [7:0] EXTENT_LAST    = 8'd5;
   localparam logic [7:0] SIZE_FIRST     = 8'd10;
   localparam logic [7:0] SIZE_LAST      = 8'd13;
   localparam logic [7:0] FLAGS_POS      = 8'd25;
   localparam logic [7:0] NAME_LEN_POS   = 8'd32;
   localparam logic [7:0] NAME_START     = 8'd33;
   localparam logic [7:0] DOT_CHAR       = 8'h00;
   localparam logic [7:0] DOTDOT_CHAR    = 8'h01;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_CORRUPT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_TARGET_LOW  = 2'd0,
      REG_TARGET_HIGH = 2'd1,
      REG_TARGET_LEN  = 2'd2,
      REG_DIR_SIZE    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] extent;
      logic [31:0] file_size;
      logic        is_directory;
   } rsp_payload_type;

   // Fold a-z to A-Z, leave everything else
   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== hdl/iso9660_directory_entry_search.sv =====
// ISO9660 directory entry search, top level.
// Depends on ides_pkg for beat types, status codes and record layout.
//
// Streams a directory one byte per beat and returns one result beat per
// search: found (with extent, size and directory flag of the first record whose
// name starts with the configured target, case-folded), not found, or corrupt
// (record length below 34). A zero length byte skips to the next sector; the
// search ends as not found at a record start once the offset reaches the
// directory size or MAX_DIRECTORY_BYTES. Bytes after the result are dropped
// until a beat with last_byte set, which closes the search (not found if it was
// still open) and rearms it. Throughput is one byte per clock; an accepted byte
// passes the input register, then the result register, to its result beat.
// The byte in the input register only waits when it would produce a result
// while the previous result is held by rsp_stall; bytes that produce no
// result keep flowing. Configure through the 64-bit APB port (registers at
// 8-byte strides) only while the block is idle.
module iso9660_directory_entry_search
   import ides_pkg::*;
#(
   parameter int SECTOR_BYTES        = SECTOR_BYTES_DEF,
   parameter int MAX_DIRECTORY_BYTES = MAX_DIRECTORY_BYTES_DEF,
   parameter int MAX_NAME_CHARS      = MAX_NAME_CHARS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   // directory byte channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   // configuration
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [4:0]      paddr,
   input  logic [63:0]     pwdata,
   output logic [63:0]     prdata,
   output logic            pready
);

   // Offset never goes past the limit plus one sector of padding
   localparam int OFFSET_W = $clog2(MAX_DIRECTORY_BYTES + SECTOR_BYTES + 1);
   localparam int SECT_W   = $clog2(SECTOR_BYTES);
   localparam logic [SECT_W-1:0]   SECTOR_LAST = SECT_W'(SECTOR_BYTES - 1);
   localparam logic [OFFSET_W-1:0] OFFSET_CAP  = OFFSET_W'(MAX_DIRECTORY_BYTES);
   localparam logic [4:0]          NAME_CAP    = 5'(MAX_NAME_CHARS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [63:0] tgt_low_ff;
   logic [63:0] tgt_high_ff;
   logic [4:0]  tgt_len_ff;
   logic [31:0] dir_bytes_ff;
   reg_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[4:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_low_ff   <= '0;
         tgt_high_ff  <= '0;
         tgt_len_ff   <= '0;
         dir_bytes_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TARGET_LOW:  tgt_low_ff   <= pwdata;
            REG_TARGET_HIGH: tgt_high_ff  <= pwdata;
            REG_TARGET_LEN:  tgt_len_ff   <= pwdata[4:0];
            REG_DIR_SIZE:    dir_bytes_ff <= pwdata[31:0];
            default:         tgt_low_ff   <= tgt_low_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TARGET_LOW:  prdata = tgt_low_ff;
         REG_TARGET_HIGH: prdata = tgt_high_ff;
         REG_TARGET_LEN:  prdata = {59'd0, tgt_len_ff};
         REG_DIR_SIZE:    prdata = {32'd0, dir_bytes_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       req_take;

   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data.data_byte;
         in_last_ff <= req_data.last_byte;
      end
   end

   // ---------------------------------------------------------------------
   // Search state
   // ---------------------------------------------------------------------
   logic [OFFSET_W-1:0] offset_ff,     offset_in;
   logic [SECT_W-1:0]   sector_pos_ff, sector_pos_in;
   logic [7:0]          rec_len_ff,    rec_len_in;
   logic [7:0]          rec_pos_ff,    rec_pos_in;
   logic [31:0]         extent_ff,     extent_in;
   logic [31:0]         size_ff,       size_in;
   logic                dir_flag_ff,   dir_flag_in;
   logic [7:0]          name_len_ff,   name_len_in;
   logic                match_ff,      match_in;
   logic                skip_ff,       skip_in;
   logic                done_ff,       done_in;

   logic                emit;
   status_type          emit_status;

   logic [OFFSET_W-1:0] offset_inc;
   logic [SECT_W-1:0]   sector_inc;
   logic                sector_wrap;
   logic                at_limit;
   logic [4:0]          tlen;
   logic [4:0]          last_idx;
   logic [7:0]          name_idx;
   logic [7:0]          tgt_char;
   logic [127:0]        tgt_all;
   logic                match_next;
   logic [1:0]          lane_ext;
   logic [1:0]          lane_size;
   logic [8:0]          pos_next;

   assign tgt_all     = {tgt_high_ff, tgt_low_ff};
   assign offset_inc  = offset_ff + 1'b1;
   assign sector_wrap = (sector_pos_ff == SECTOR_LAST);
   assign sector_inc  = sector_wrap ? '0 : sector_pos_ff + 1'b1;
   assign at_limit    = (32'(offset_ff) >= dir_bytes_ff) || (offset_ff >= OFFSET_CAP);
   assign tlen        = (tgt_len_ff > NAME_CAP) ? NAME_CAP : tgt_len_ff;
   assign last_idx    = (tlen == 5'd0) ? 5'd0 : tlen - 5'd1;
   assign name_idx    = rec_pos_ff - NAME_START;
   assign tgt_char    = tgt_all[{name_idx[3:0], 3'b000} +: 8];
   assign lane_ext    = 2'(rec_pos_ff - EXTENT_FIRST);
   assign lane_size   = 2'(rec_pos_ff - SIZE_FIRST);
   assign pos_next    = {1'b0, rec_pos_ff} + 9'd1;

   always_comb begin
      offset_in     = offset_ff;
      sector_pos_in = sector_pos_ff;
      rec_len_in    = rec_len_ff;
      rec_pos_in    = rec_pos_ff;
      extent_in     = extent_ff;
      size_in       = size_ff;
      dir_flag_in   = dir_flag_ff;
      name_len_in   = name_len_ff;
      match_in      = match_ff;
      skip_in       = skip_ff;
      done_in       = done_ff;
      emit          = 1'b0;
      emit_status   = ST_NOT_FOUND;
      match_next    = match_ff;

      if (!done_ff) begin
         priority if (skip_ff) begin
            // sector padding: advance until the boundary
            offset_in     = offset_inc;
            sector_pos_in = sector_inc;
            if (sector_wrap) begin
               skip_in = 1'b0;
            end
         end else if (rec_pos_ff == 8'd0) begin
            // record start: length byte
            if (at_limit) begin
               emit        = 1'b1;
               emit_status = ST_NOT_FOUND;
            end else begin
               offset_in     = offset_inc;
               sector_pos_in = sector_inc;
               priority if (in_byte_ff == 8'd0) begin
                  if (!sector_wrap) begin
                     skip_in = 1'b1;
                  end
               end else if (in_byte_ff < MIN_RECORD_LEN) begin
                  emit        = 1'b1;
                  emit_status = ST_CORRUPT;
               end else begin
                  rec_len_in  = in_byte_ff;
                  rec_pos_in  = 8'd1;
                  extent_in   = '0;
                  size_in     = '0;
                  dir_flag_in = 1'b0;
                  name_len_in = '0;
                  match_in    = 1'b1;
               end
            end
         end else begin
            // record body
            offset_in     = offset_inc;
            sector_pos_in = sector_inc;
            priority if (rec_pos_ff >= EXTENT_FIRST && rec_pos_ff <= EXTENT_LAST) begin
               extent_in[{lane_ext, 3'b000} +: 8] = in_byte_ff;
            end else if (rec_pos_ff >= SIZE_FIRST && rec_pos_ff <= SIZE_LAST) begin
               size_in[{lane_size, 3'b000} +: 8] = in_byte_ff;
            end else if (rec_pos_ff == FLAGS_POS) begin
               dir_flag_in = in_byte_ff[1];
            end else if (rec_pos_ff == NAME_LEN_POS) begin
               name_len_in = in_byte_ff;
            end else if (rec_pos_ff >= NAME_START) begin
               // dot entries and empty names never match
               if (name_idx == 8'd0 && (name_len_ff == 8'd0 || in_byte_ff == DOT_CHAR ||
                                        in_byte_ff == DOTDOT_CHAR)) begin
                  match_next = 1'b0;
               end
               if (name_idx < {3'b000, tlen}) begin
                  if (name_idx >= name_len_ff || upcase(in_byte_ff) != upcase(tgt_char)) begin
                     match_next = 1'b0;
                  end
               end
               match_in = match_next;
               if (name_idx == {3'b000, last_idx} && match_next) begin
                  emit        = 1'b1;
                  emit_status = ST_FOUND;
               end
            end else begin
               match_in = match_ff;
            end
            if (!emit) begin
               rec_pos_in = (pos_next >= {1'b0, rec_len_ff}) ? 8'd0 : pos_next[7:0];
            end
         end
      end

      if (emit) begin
         done_in = 1'b1;
      end

      if (in_last_ff) begin
         // close an open search, then rearm
         if (!emit && !done_ff) begin
            emit        = 1'b1;
            emit_status = ST_NOT_FOUND;
         end
         offset_in     = '0;
         sector_pos_in = '0;
         rec_len_in    = '0;
         rec_pos_in    = '0;
         extent_in     = '0;
         size_in       = '0;
         dir_flag_in   = 1'b0;
         name_len_in   = '0;
         match_in      = 1'b1;
         skip_in       = 1'b0;
         done_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         sector_pos_ff <= '0;
         rec_len_ff    <= '0;
         rec_pos_ff    <= '0;
         extent_ff     <= '0;
         size_ff       <= '0;
         dir_flag_ff   <= 1'b0;
         name_len_ff   <= '0;
         match_ff      <= 1'b1;
         skip_ff       <= 1'b0;
         done_ff       <= 1'b0;
      end else if (advance) begin
         offset_ff     <= offset_in;
         sector_pos_ff <= sector_pos_in;
         rec_len_ff    <= rec_len_in;
         rec_pos_ff    <= rec_pos_in;
         extent_ff     <= extent_in;
         size_ff       <= size_in;
         dir_flag_ff   <= dir_flag_in;
         name_len_ff   <= name_len_in;
         match_ff      <= match_in;
         skip_ff       <= skip_in;
         done_ff       <= done_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            out_free;

   // Hold the byte only when it would overwrite a result still held downstream
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && (out_free || !emit);

   always_comb begin
      rsp_data_in.status       = emit_status;
      rsp_data_in.extent       = (emit_status == ST_FOUND) ? extent_ff : 32'd0;
      rsp_data_in.file_size    = (emit_status == ST_FOUND) ? size_ff : 32'd0;
      rsp_data_in.is_directory = (emit_status == ST_FOUND) && dir_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/ides_checker.sv =====
// Port-level checks for the ISO9660 directory entry search block.
// Depends on ides_pkg; bound to iso9660_directory_entry_search below.
module ides_checker
   import ides_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // only a found result carries entry fields
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FOUND |->
         rsp_data.extent == 32'd0 && rsp_data.file_size == 32'd0 && !rsp_data.is_directory)
      else $error("entry fields set on a result that is not found");

   // never back-pressure bytes while the result slot is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("byte channel stalled with no result pending");

   // reset drops any result and input beat
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state survived reset");

endmodule

bind iso9660_directory_entry_search ides_checker u_ides_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb.sv =====
// Self-checking bench for the ISO9660 directory entry search block.
// Needs ides_pkg for the beat types and status codes, and the search block itself.
// Streams synthetic directory records through the byte channel and checks every result beat.
module tb;
   import ides_pkg::*;

   localparam int SECTOR        = 2048;
   localparam int DIR_CAP       = 16384;
   localparam int NAME_CHARS    = 16;
   localparam int MIN_LEN       = 34;
   localparam int EXTENT_AT     = 2;
   localparam int SIZE_AT       = 10;
   localparam int FLAGS_AT      = 25;
   localparam int NAME_LEN_AT   = 32;
   localparam int NAME_AT       = 33;
   localparam int IDLE_PCT      = 36;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_BEATS  = 1300;
   localparam int MIN_SEARCHES  = 10;

   typedef enum int {
      NAME_HIT,
      NAME_NEAR,
      NAME_DOT,
      NAME_CUT,
      NAME_RANDOM
   } name_kind_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            psel      = 1'b0;
   logic            penable   = 1'b0;
   logic            pwrite    = 1'b0;
   logic [4:0]      paddr     = '0;
   logic [63:0]     pwdata    = '0;
   logic [63:0]     prdata;
   logic            pready;

   iso9660_directory_entry_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Register copies, as last written through the configuration port
   // ---------------------------------------------------------------------
   logic [63:0] shadow_name_low  = '0;
   logic [63:0] shadow_name_high = '0;
   logic [4:0]  shadow_name_len  = '0;
   logic [31:0] shadow_dir_bytes = '0;

   // ---------------------------------------------------------------------
   // Directory walker: tracks the search exactly as the block should and
   // records the result beat each search must end with
   // ---------------------------------------------------------------------
   int unsigned     walk_offset;
   int unsigned     walk_rec_len;
   int unsigned     walk_pos;
   int unsigned     walk_name_len;
   logic [31:0]     walk_extent;
   logic [31:0]     walk_size;
   logic            walk_dir;
   bit              walk_name_ok;
   bit              walk_padding;
   bit              walk_done;
   rsp_payload_type predicted_outcomes[$];
   int              found_count   = 0;
   int              missing_count = 0;
   int              corrupt_count = 0;
   int              beats_walked  = 0;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

   function automatic logic [7:0] target_char(input int unsigned i);
      logic [63:0] word;
      word = (i < 8) ? shadow_name_low : shadow_name_high;
      return word[8*(i%8) +: 8];
   endfunction

   task automatic rearm_walk();
      walk_offset   = 0;
      walk_rec_len  = 0;
      walk_pos      = 0;
      walk_extent   = '0;
      walk_size     = '0;
      walk_dir      = 1'b0;
      walk_name_len = 0;
      walk_name_ok  = 1'b1;
      walk_padding  = 1'b0;
      walk_done     = 1'b0;
   endtask

   // Close the search; only a found result carries the record fields
   task automatic close_search(input status_type st);
      rsp_payload_type r;
      r.status       = st;
      r.extent       = (st == ST_FOUND) ? walk_extent : '0;
      r.file_size    = (st == ST_FOUND) ? walk_size : '0;
      r.is_directory = (st == ST_FOUND) ? walk_dir : 1'b0;
      predicted_outcomes.push_back(r);
      walk_done = 1'b1;
      case (st)
         ST_FOUND:     found_count++;
         ST_NOT_FOUND: missing_count++;
         default:      corrupt_count++;
      endcase
   endtask

   task automatic walk_byte(input logic [7:0] b);
      int unsigned p;
      int unsigned idx;
      int unsigned tlen;
      int unsigned last;
      p = walk_pos;
      // Count padding bytes up to the next sector boundary, content unused
      if (walk_padding) begin
         walk_offset++;
         if (walk_offset % SECTOR == 0) walk_padding = 1'b0;
         return;
      end
      if (p == 0) begin
         // End check: the byte at a record start at or past the limit is dropped
         if (walk_offset >= shadow_dir_bytes || walk_offset >= DIR_CAP) begin
            close_search(ST_NOT_FOUND);
            return;
         end
         walk_offset++;
         if (b == 8'h00) begin
            if (walk_offset % SECTOR != 0) walk_padding = 1'b1;
            return;
         end
         if (b < MIN_LEN) begin
            close_search(ST_CORRUPT);
            return;
         end
         walk_rec_len  = b;
         walk_pos      = 1;
         walk_extent   = '0;
         walk_size     = '0;
         walk_dir      = 1'b0;
         walk_name_len = 0;
         walk_name_ok  = 1'b1;
         return;
      end
      walk_offset++;
      if (p >= EXTENT_AT && p <= EXTENT_AT + 3) begin
         walk_extent[8*(p-EXTENT_AT) +: 8] = walk_extent[8*(p-EXTENT_AT) +: 8] | b;
      end else if (p >= SIZE_AT && p <= SIZE_AT + 3) begin
         walk_size[8*(p-SIZE_AT) +: 8] = walk_size[8*(p-SIZE_AT) +: 8] | b;
      end else if (p == FLAGS_AT) begin
         walk_dir = b[1];
      end else if (p == NAME_LEN_AT) begin
         walk_name_len = b;
      end else if (p >= NAME_AT) begin
         idx  = p - NAME_AT;
         tlen = (shadow_name_len > NAME_CHARS) ? NAME_CHARS : shadow_name_len;
         last = (tlen == 0) ? 0 : tlen - 1;
         // Dot entries and empty names never match
         if (idx == 0 && (walk_name_len == 0 || b == 8'h00 || b == 8'h01))
            walk_name_ok = 1'b0;
         if (idx < tlen &&
             (idx >= walk_name_len || fold_case(b) != fold_case(target_char(idx))))
            walk_name_ok = 1'b0;
         // Decide as soon as the last target character has been seen
         if (idx == last && walk_name_ok) begin
            close_search(ST_FOUND);
            return;
         end
      end
      if (p + 1 >= walk_rec_len) walk_pos = 0;
      else walk_pos = p + 1;
   endtask

   task automatic walk_beat(input req_payload_type beat);
      if (!walk_done) walk_byte(beat.data_byte);
      // The last byte closes an open search as not found and rearms
      if (beat.last_byte) begin
         if (!walk_done) close_search(ST_NOT_FOUND);
         rearm_walk();
      end
   endtask

   // Walk every accepted byte beat
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         walk_beat(req_data);
         beats_walked++;
      end
   end

   // ---------------------------------------------------------------------
   // Byte driver: feeds pending beats, idles at random when allowed
   // ---------------------------------------------------------------------
   req_payload_type byte_beats[$];
   bit              idle_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // Slot is free: offer the next beat or drop valid and idle
         if (byte_beats.size() > 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data  <= byte_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted result beat against the oldest prediction
   // ---------------------------------------------------------------------
   int mismatch_count = 0;

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result beat with none pending: status=%0d extent=%h size=%h dir=%b",
                        $time, rsp_data.status, rsp_data.extent, rsp_data.file_size,
                        rsp_data.is_directory);
         end else begin
            want = predicted_outcomes.pop_front();
            if (rsp_data.status !== want.status || rsp_data.extent !== want.extent ||
                rsp_data.file_size !== want.file_size ||
                rsp_data.is_directory !== want.is_directory) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: mismatch: want status=%0d extent=%h size=%h dir=%b, %s",
                           $time, want.status, want.extent, want.file_size, want.is_directory,
                           $sformatf("got status=%0d extent=%h size=%h dir=%b",
                                     rsp_data.status, rsp_data.extent, rsp_data.file_size,
                                     rsp_data.is_directory));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Configuration writes and stimulus generation
   // ---------------------------------------------------------------------
   logic [7:0] target_text [NAME_CHARS];
   int         target_used     = 0;
   int         beats_counted   = 0;
   int         searches_queued = 0;
   int         setting_count   = 0;

   task automatic write_register(input reg_index_type idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      // Access phase ends at the first edge with pready high
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TARGET_LOW:  shadow_name_low  = value;
         REG_TARGET_HIGH: shadow_name_high = value;
         REG_TARGET_LEN:  shadow_name_len  = value[4:0];
         default:         shadow_dir_bytes = value[31:0];
      endcase
   endtask

   task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [31:0] dir_bytes);
      write_register(REG_TARGET_LOW, lo);
      write_register(REG_TARGET_HIGH, hi);
      write_register(REG_TARGET_LEN, {59'd0, len});
      write_register(REG_DIR_SIZE, {32'd0, dir_bytes});
      target_used = (len > NAME_CHARS) ? NAME_CHARS : len;
      setting_count++;
   endtask

   // Hold the sender until every prediction is met, then let trailing
   // ignored bytes clear the block
   task automatic settle();
      while (byte_beats.size() > 0 || req_valid || predicted_outcomes.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void add_beat(input logic [7:0] b, input bit last, input bit counted);
      req_payload_type t;
      t.data_byte = b;
      t.last_byte = last;
      byte_beats.push_back(t);
      if (counted) beats_counted++;
   endfunction

   function automatic logic [7:0] name_char();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 8'h41 + 8'($urandom_range(25));
      if (r < 70) return 8'h61 + 8'($urandom_range(25));
      if (r < 85) return 8'h30 + 8'($urandom_range(9));
      if (r < 90) return 8'h5F;
      if (r < 95) return 8'h2E;
      return 8'h3B;
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      logic [7:0] up;
      up = fold_case(c);
      if (up >= 8'h41 && up <= 8'h5A && $urandom_range(1) == 1) return c ^ 8'h20;
      return c;
   endfunction

   function automatic name_kind_type pick_name_kind();
      int r;
      r = $urandom_range(99);
      if (r < 30) return NAME_HIT;
      if (r < 50) return NAME_NEAR;
      if (r < 65) return NAME_DOT;
      if (r < 75) return NAME_CUT;
      return NAME_RANDOM;
   endfunction

   // Zero length byte and a little noise; the rest of the search is padding
   task automatic pad_sector(ref int off);
      add_beat(8'h00, 1'b0, 1'b1);
      off++;
      repeat ($urandom_range(4)) begin
         add_beat(8'($urandom_range(255)), 1'b0, 1'b1);
         off++;
      end
   endtask

   task automatic append_record(ref int off, input name_kind_type kind);
      logic [7:0] name[$];
      logic [7:0] c;
      int         declared;
      int         len;
      int         k;
      int         pos;
      if (target_used == 0 && kind != NAME_DOT) kind = NAME_RANDOM;
      case (kind)
         NAME_HIT, NAME_NEAR, NAME_CUT: begin
            for (k = 0; k < target_used; k++) name.push_back(flip_case(target_text[k]));
            if (kind == NAME_HIT) begin
               // Version suffix and the like must not spoil a prefix match
               repeat ($urandom_range(3)) name.push_back(name_char());
            end else if (kind == NAME_NEAR) begin
               pos = $urandom_range(target_used - 1);
               do c = 8'($urandom_range(255)); while (fold_case(c) == fold_case(name[pos]));
               name[pos] = c;
            end
            declared = name.size();
            // Declare fewer characters than the record really carries
            if (kind == NAME_CUT) declared = $urandom_range(target_used - 1);
         end
         NAME_DOT: begin
            name.push_back(8'($urandom_range(1)));
            declared = 1;
         end
         default: begin
            repeat ($urandom_range(20, 1)) name.push_back(name_char());
            declared = ($urandom_range(99) < 5) ? 0 : name.size();
         end
      endcase
      len = NAME_AT + name.size() + $urandom_range(3);
      // Now and then end the record before its name does
      if ($urandom_range(99) < 8) len = $urandom_range(len, MIN_LEN);
      if (len > 255) len = 255;
      for (pos = 0; pos < len; pos++) begin
         if (pos == 0) c = 8'(len);
         else if (pos == NAME_LEN_AT) c = 8'(declared);
         else if (pos >= NAME_AT && pos - NAME_AT < name.size()) c = name[pos - NAME_AT];
         else c = 8'($urandom_range(255));
         add_beat(c, 1'b0, 1'b1);
      end
      off += len;
   endtask

   task automatic queue_search(input int max_records);
      req_payload_type t;
      int              off;
      int              r;
      int              start;
      int              pick;
      off   = 0;
      start = byte_beats.size();
      for (r = $urandom_range(max_records); r > 0; r--) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            pad_sector(off);
         end else if (pick < 9) begin
            add_beat(8'($urandom_range(MIN_LEN - 1, 1)), 1'b0, 1'b1);
            off++;
         end else begin
            append_record(off, pick_name_kind());
         end
      end
      // End the stream on the final byte or after a few stray ones
      if (byte_beats.size() > start && $urandom_range(99) < 30) begin
         t = byte_beats.pop_back();
         t.last_byte = 1'b1;
         byte_beats.push_back(t);
      end else begin
         repeat ($urandom_range(2)) add_beat(8'($urandom_range(255)), 1'b0, 1'b1);
         add_beat(8'($urandom_range(255)), 1'b1, 1'b1);
      end
      searches_queued++;
   endtask

   task automatic pick_target(output logic [63:0] lo, output logic [63:0] hi,
                              output logic [4:0] len);
      int n;
      int k;
      n = $urandom_range(NAME_CHARS, 1);
      for (k = 0; k < NAME_CHARS; k++)
         target_text[k] = (k < n) ? name_char() : 8'($urandom_range(255));
      // A zero character inside the target is compared like any other
      if (n > 1 && $urandom_range(99) < 15) target_text[$urandom_range(n - 1, 1)] = 8'h00;
      k = $urandom_range(99);
      if (k < 10) len = 5'd0;
      else if (k < 22) len = 5'($urandom_range(31, NAME_CHARS + 1));
      else len = 5'(n);
      for (k = 0; k < 8; k++) begin
         lo[8*k +: 8] = target_text[k];
         hi[8*k +: 8] = target_text[k + 8];
      end
   endtask

   task automatic random_phase(input int searches);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      logic [31:0] dir_bytes;
      int          k;
      pick_target(lo, hi, len);
      k = $urandom_range(99);
      if (k < 25) dir_bytes = $urandom_range(400);
      else if (k < 50) dir_bytes = $urandom_range(3000, 400);
      else if (k < 75) dir_bytes = $urandom();
      else dir_bytes = 32'hFFFF_FFFF;
      configure(lo, hi, len, dir_bytes);
      @(negedge clock);
      repeat (searches) queue_search(4);
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      int phase;
      int random_start;
      int search_start;
      int s;
      int off;
      rearm_walk();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Zero directory size: the first record start already ends the search
      configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 32'd0);
      @(negedge clock);
      add_beat(8'hFF, 1'b1, 1'b1);
      add_beat(8'h00, 1'b1, 1'b1);
      settle();

      // Open-ended size: short lengths, early stream end, padding, ignored tail
      configure(64'd0, 64'd0, 5'd0, 32'hFFFF_FFFF);
      @(negedge clock);
      add_beat(8'h01, 1'b1, 1'b1);
      add_beat(8'h21, 1'b1, 1'b1);
      add_beat(8'h22, 1'b1, 1'b1);
      add_beat(8'h00, 1'b1, 1'b1);
      add_beat(8'h00, 1'b0, 1'b1);
      add_beat(8'hAA, 1'b0, 1'b1);
      add_beat(8'h13, 1'b1, 1'b1);
      add_beat(8'hFF, 1'b0, 1'b1);
      add_beat(8'h55, 1'b1, 1'b1);
      add_beat(8'h05, 1'b0, 1'b1);
      add_beat(8'hFF, 1'b0, 1'b1);
      add_beat(8'h00, 1'b1, 1'b1);
      settle();

      // A few dot entries, then the directory size ends the search
      configure(64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 5'd16, 32'd80);
      @(negedge clock);
      off = 0;
      repeat (4) append_record(off, NAME_DOT);
      add_beat(8'($urandom_range(255)), 1'b1, 1'b1);
      settle();

      // Back-to-back one-byte searches against a long receiver hold-off:
      // results pile up and the block must stall its input
      configure(64'd0, 64'd0, 5'd0, 32'hFFFF_FFFF);
      @(negedge clock);
      idle_on = 1'b0;
      hold_requests++;
      repeat (60) begin
         s = $urandom_range(2);
         if (s == 0) add_beat(8'($urandom_range(MIN_LEN - 1, 1)), 1'b1, 1'b1);
         else if (s == 1) add_beat(8'($urandom_range(255, MIN_LEN)), 1'b1, 1'b1);
         else add_beat(8'h00, 1'b1, 1'b1);
      end
      settle();
      idle_on = 1'b1;

      // Random directories under fresh settings; one long phase runs flat out
      random_start = beats_counted;
      search_start = searches_queued;
      phase = 0;
      while (beats_counted - random_start < RANDOM_BEATS ||
             searches_queued - search_start < MIN_SEARCHES) begin
         idle_on = (phase != 2);
         random_phase((phase == 2) ? 6 : $urandom_range(4, 2));
         phase++;
      end
      idle_on = 1'b1;
      settle();

      $display("Walked %0d directory bytes in %0d searches across %0d register settings.",
               beats_walked, searches_queued, setting_count);
      $display("Outcomes: %0d found, %0d not found, %0d corrupt; %0d mismatches.",
               found_count, missing_count, corrupt_count, mismatch_count);
      if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run
   initial begin
      #(12 * 1500000);
      $display("Timeout with %0d results outstanding.", predicted_outcomes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
